@@ design/pmd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the point-to-mesh distance block.
// Holds the datapath widths, command codes and the multiply-accumulate program.
// No dependencies.
package pmd_pkg;

    localparam int COORD_W  = 32;
    localparam int IDX_W    = 12;
    localparam int CMD_W    = 2;
    localparam int CFG_W    = 13;
    localparam int DIFF_W   = 33;   // coordinate differences
    localparam int DOT_W    = 68;   // sums of three difference products
    localparam int OP_W     = 72;   // multiplier operand magnitude
    localparam int CHUNK_W  = 18;   // operand B slice per cycle
    localparam int ACC_W    = 140;  // accumulator, holds det, s, t and residual sums
    localparam int FRAC_W   = 33;   // barycentric fraction, 1.0 = 2^32
    localparam int STEP_W   = 5;
    localparam int ITER_W   = 5;

    localparam logic [CMD_W-1:0] CMD_VERTEX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FACE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STEP_W-1:0] STEP_PRE_LAST   = 5'd20;
    localparam logic [STEP_W-1:0] STEP_POST_FIRST = 5'd21;
    localparam logic [STEP_W-1:0] STEP_LAST       = 5'd29;

    localparam logic [1:0]        CHUNK_LAST = 2'd3;
    localparam logic [ITER_W-1:0] ITER_LAST  = 5'd31;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 33'h1_0000_0000;

    typedef enum logic [4:0] {
        OP_Q0, OP_Q1, OP_Q2,
        OP_E00, OP_E01, OP_E02,
        OP_E10, OP_E11, OP_E12,
        OP_A, OP_B, OP_C, OP_D, OP_E,
        OP_SF, OP_TF, OP_R
    } opnd_t;

    typedef enum logic [2:0] {
        INIT_ZERO, INIT_KEEP, INIT_Q0, INIT_Q1, INIT_Q2, INIT_X
    } init_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_A, DST_B, DST_C, DST_D, DST_E,
        DST_DET, DST_S, DST_T, DST_R, DST_X
    } dst_t;

    typedef struct packed {
        opnd_t sa;
        opnd_t sb;
        init_t init;
        logic  sub;
        dst_t  dst;
    } mul_op_t;

    typedef enum logic [2:0] {
        FM_ZERO, FM_SF, FM_TF, FM_SF_COMP, FM_TF_COMP, FM_BOTH
    } frac_mode_t;

    // Steps 0..20: dot products and cross terms. Steps 21..29: residual and its square.
    function automatic mul_op_t mul_prog(input logic [STEP_W-1:0] step);
        mul_op_t op;
        unique case (step)
            5'd0:  op = '{OP_E00, OP_E00, INIT_ZERO, 1'b0, DST_NONE};
            5'd1:  op = '{OP_E01, OP_E01, INIT_KEEP, 1'b0, DST_NONE};
            5'd2:  op = '{OP_E02, OP_E02, INIT_KEEP, 1'b0, DST_A};
            5'd3:  op = '{OP_E00, OP_E10, INIT_ZERO, 1'b0, DST_NONE};
            5'd4:  op = '{OP_E01, OP_E11, INIT_KEEP, 1'b0, DST_NONE};
            5'd5:  op = '{OP_E02, OP_E12, INIT_KEEP, 1'b0, DST_B};
            5'd6:  op = '{OP_E10, OP_E10, INIT_ZERO, 1'b0, DST_NONE};
            5'd7:  op = '{OP_E11, OP_E11, INIT_KEEP, 1'b0, DST_NONE};
            5'd8:  op = '{OP_E12, OP_E12, INIT_KEEP, 1'b0, DST_C};
            5'd9:  op = '{OP_E00, OP_Q0,  INIT_ZERO, 1'b0, DST_NONE};
            5'd10: op = '{OP_E01, OP_Q1,  INIT_KEEP, 1'b0, DST_NONE};
            5'd11: op = '{OP_E02, OP_Q2,  INIT_KEEP, 1'b0, DST_D};
            5'd12: op = '{OP_E10, OP_Q0,  INIT_ZERO, 1'b0, DST_NONE};
            5'd13: op = '{OP_E11, OP_Q1,  INIT_KEEP, 1'b0, DST_NONE};
            5'd14: op = '{OP_E12, OP_Q2,  INIT_KEEP, 1'b0, DST_E};
            5'd15: op = '{OP_A,   OP_C,   INIT_ZERO, 1'b0, DST_NONE};
            5'd16: op = '{OP_B,   OP_B,   INIT_KEEP, 1'b1, DST_DET};
            5'd17: op = '{OP_B,   OP_E,   INIT_ZERO, 1'b0, DST_NONE};
            5'd18: op = '{OP_C,   OP_D,   INIT_KEEP, 1'b1, DST_S};
            5'd19: op = '{OP_B,   OP_D,   INIT_ZERO, 1'b0, DST_NONE};
            5'd20: op = '{OP_A,   OP_E,   INIT_KEEP, 1'b1, DST_T};
            5'd21: op = '{OP_SF,  OP_E00, INIT_Q0,   1'b1, DST_NONE};
            5'd22: op = '{OP_TF,  OP_E10, INIT_KEEP, 1'b1, DST_R};
            5'd23: op = '{OP_R,   OP_R,   INIT_ZERO, 1'b0, DST_X};
            5'd24: op = '{OP_SF,  OP_E01, INIT_Q1,   1'b1, DST_NONE};
            5'd25: op = '{OP_TF,  OP_E11, INIT_KEEP, 1'b1, DST_R};
            5'd26: op = '{OP_R,   OP_R,   INIT_X,    1'b0, DST_X};
            5'd27: op = '{OP_SF,  OP_E02, INIT_Q2,   1'b1, DST_NONE};
            5'd28: op = '{OP_TF,  OP_E12, INIT_KEEP, 1'b1, DST_R};
            5'd29: op = '{OP_R,   OP_R,   INIT_X,    1'b0, DST_X};
            default: op = '{OP_Q0, OP_Q0, INIT_ZERO, 1'b0, DST_NONE};
        endcase
        return op;
    endfunction

endpackage

@@ design/pmd_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pmd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/point_mesh_min_distance_top.sv @@
`timescale 1ns / 1ps
// Point to triangle mesh distance, brute force over all loaded faces.
// Depends on pmd_pkg and pmd_ram.
//
// Usage: the item channel (item_valid/item_ready) carries commands. cmd 0 writes a
// vertex, cmd 1 writes a face (three corner indices); both write commands
// return nothing. cmd 2 queries a point and returns one transfer on the result
// channel (result_valid/result_ready) with the distance and the empty_mesh flag.
// The user writes face_count through cfg_we/cfg_data while the block is idle; the
// block does not enforce this. Each face goes through a sequencer around one shared
// 72x18 multiply-accumulate unit (30 products) and a one-bit-per-cycle divider for
// the barycentric fractions. After the last face a square root runs, skipped when
// the distance saturates. Items are taken one at a time.
// Vertex and face stores are RAMs with no reset; reading an unwritten entry is
// undefined. Reset clears face_count and the control state.
// The result sits in an output register: while the receiver stalls, writes are
// still accepted, and a finished query waits until the register is free.
module point_mesh_min_distance_top
    import pmd_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_FACES    = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic [CMD_W-1:0]          cmd,
    input  logic [IDX_W-1:0]          slot,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic [IDX_W-1:0]          corner_a,
    input  logic [IDX_W-1:0]          corner_b,
    input  logic [IDX_W-1:0]          corner_c,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [COORD_W-1:0]        distance,
    output logic                      empty_mesh,
    input  logic                      cfg_we,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int VADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FADDR_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CNT_W   = $clog2(MAX_FACES + 1);
    localparam int VERT_W  = 3 * COORD_W;
    localparam int FACE_W  = 3 * IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_FACE, S_VA, S_VB, S_VC, S_VD, S_MUL, S_CLASS,
        S_FRAC, S_DIV, S_FDONE, S_CMP, S_SQRT, S_DONE
    } state_t;

    state_t               state_reg;
    logic [CFG_W-1:0]     fc_reg;
    logic [CNT_W-1:0]     face_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [1:0]           chunk_reg;
    logic [ITER_W-1:0]    iter_reg;
    logic                 second_reg;
    logic                 have_reg;
    logic                 result_valid_reg;
    logic [COORD_W-1:0]   distance_reg;
    logic                 empty_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [COORD_W-1:0] v0x_reg, v0y_reg, v0z_reg;
    logic signed [DIFF_W-1:0]  q0_reg, q1_reg, q2_reg;
    logic signed [DIFF_W-1:0]  e00_reg, e01_reg, e02_reg;
    logic signed [DIFF_W-1:0]  e10_reg, e11_reg, e12_reg;
    logic signed [DOT_W-1:0]   a_reg, b_reg, c_reg, d_reg, e_reg;
    logic signed [ACC_W-1:0]   det_reg, s_reg, t_reg;
    logic signed [ACC_W-1:0]   acc_reg, x_reg, best_reg;
    logic signed [OP_W-1:0]    r_reg;
    logic [FRAC_W-1:0]         sf_reg, tf_reg, f_reg;
    frac_mode_t                mode_reg;
    logic signed [ACC_W-1:0]   num_reg, den_reg;
    logic [ACC_W-1:0]          rem_reg;
    logic [31:0]               quo_reg;
    logic [63:0]               sq_y_reg, sq_res_reg;
    logic [COORD_W-1:0]        pend_dist_reg;
    logic                      pend_empty_reg;
    logic [IDX_W-1:0]          corner_b_reg, corner_c_reg;
    logic                      vout_reg;

    logic                  item_fire;
    logic                  load_result;
    logic [CNT_W-1:0]      n_calc;
    logic                  last_face;

    // Stores
    logic                  vert_we, face_we;
    logic [VERT_W-1:0]     vert_rdata;
    logic [FACE_W-1:0]     face_rdata;
    logic [IDX_W-1:0]      vcorner;
    logic [VADDR_W-1:0]    vert_raddr;
    logic                  vcorner_out;

    assign item_fire = item_valid && item_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign load_result = (state_reg == S_DONE) && (!result_valid_reg || result_ready);
    assign vert_we = item_fire && (cmd == CMD_VERTEX) && (32'(slot) < 32'(MAX_VERTICES));
    assign face_we = item_fire && (cmd == CMD_FACE) && (32'(slot) < 32'(MAX_FACES));

    always_comb
    begin
        unique case (state_reg)
            S_VA:    vcorner = face_rdata[3*IDX_W-1:2*IDX_W];
            S_VB:    vcorner = corner_b_reg;
            default: vcorner = corner_c_reg;
        endcase
    end

    assign vert_raddr  = VADDR_W'(vcorner);
    assign vcorner_out = !(32'(vcorner) < 32'(MAX_VERTICES));

    pmd_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_vert_ram (
        .clk   (clk),
        .we    (vert_we),
        .waddr (VADDR_W'(slot)),
        .wdata ({coord_x, coord_y, coord_z}),
        .raddr (vert_raddr),
        .rdata (vert_rdata)
    );

    pmd_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_face_ram (
        .clk   (clk),
        .we    (face_we),
        .waddr (FADDR_W'(slot)),
        .wdata ({corner_a, corner_b, corner_c}),
        .raddr (FADDR_W'(face_reg)),
        .rdata (face_rdata)
    );

    // Vertex read data, zero for a corner beyond the store
    logic signed [COORD_W-1:0] vcx, vcy, vcz;
    assign vcx = vout_reg ? '0 : $signed(vert_rdata[3*COORD_W-1:2*COORD_W]);
    assign vcy = vout_reg ? '0 : $signed(vert_rdata[2*COORD_W-1:COORD_W]);
    assign vcz = vout_reg ? '0 : $signed(vert_rdata[COORD_W-1:0]);

    assign n_calc = (32'(fc_reg) > 32'(MAX_FACES)) ? CNT_W'(MAX_FACES) : CNT_W'(fc_reg);
    assign last_face = ((face_reg + CNT_W'(1)) == n_reg);

    // Multiply-accumulate unit
    mul_op_t                 op;
    logic signed [OP_W-1:0]  av, bv;
    logic [OP_W-1:0]         mag_a, mag_b;
    logic                    mul_neg;
    logic [CHUNK_W-1:0]      b_chunk;
    logic [OP_W+CHUNK_W-1:0] pp;
    logic signed [ACC_W-1:0] pp_sh, base, acc_next;

    assign op = mul_prog(step_reg);

    always_comb
    begin
        unique case (op.sa)
            OP_Q0:   av = OP_W'(q0_reg);
            OP_Q1:   av = OP_W'(q1_reg);
            OP_Q2:   av = OP_W'(q2_reg);
            OP_E00:  av = OP_W'(e00_reg);
            OP_E01:  av = OP_W'(e01_reg);
            OP_E02:  av = OP_W'(e02_reg);
            OP_E10:  av = OP_W'(e10_reg);
            OP_E11:  av = OP_W'(e11_reg);
            OP_E12:  av = OP_W'(e12_reg);
            OP_A:    av = OP_W'(a_reg);
            OP_B:    av = OP_W'(b_reg);
            OP_C:    av = OP_W'(c_reg);
            OP_D:    av = OP_W'(d_reg);
            OP_E:    av = OP_W'(e_reg);
            OP_SF:   av = $signed({{(OP_W-FRAC_W){1'b0}}, sf_reg});
            OP_TF:   av = $signed({{(OP_W-FRAC_W){1'b0}}, tf_reg});
            OP_R:    av = r_reg;
            default: av = '0;
        endcase
        unique case (op.sb)
            OP_Q0:   bv = OP_W'(q0_reg);
            OP_Q1:   bv = OP_W'(q1_reg);
            OP_Q2:   bv = OP_W'(q2_reg);
            OP_E00:  bv = OP_W'(e00_reg);
            OP_E01:  bv = OP_W'(e01_reg);
            OP_E02:  bv = OP_W'(e02_reg);
            OP_E10:  bv = OP_W'(e10_reg);
            OP_E11:  bv = OP_W'(e11_reg);
            OP_E12:  bv = OP_W'(e12_reg);
            OP_A:    bv = OP_W'(a_reg);
            OP_B:    bv = OP_W'(b_reg);
            OP_C:    bv = OP_W'(c_reg);
            OP_D:    bv = OP_W'(d_reg);
            OP_E:    bv = OP_W'(e_reg);
            OP_SF:   bv = $signed({{(OP_W-FRAC_W){1'b0}}, sf_reg});
            OP_TF:   bv = $signed({{(OP_W-FRAC_W){1'b0}}, tf_reg});
            OP_R:    bv = r_reg;
            default: bv = '0;
        endcase
    end

    always_comb
    begin
        mul_neg = av[OP_W-1] ^ bv[OP_W-1] ^ op.sub;
        mag_a   = av[OP_W-1] ? OP_W'(-av) : OP_W'(av);
        mag_b   = bv[OP_W-1] ? OP_W'(-bv) : OP_W'(bv);
        b_chunk = mag_b[chunk_reg*CHUNK_W +: CHUNK_W];
        pp      = mag_a * b_chunk;
        pp_sh   = $signed(ACC_W'(pp) << (chunk_reg * CHUNK_W));
        if (chunk_reg == 2'd0)
        begin
            unique case (op.init)
                INIT_ZERO: base = '0;
                INIT_KEEP: base = acc_reg;
                INIT_Q0:   base = ACC_W'(q0_reg) <<< 32;
                INIT_Q1:   base = ACC_W'(q1_reg) <<< 32;
                INIT_Q2:   base = ACC_W'(q2_reg) <<< 32;
                INIT_X:    base = x_reg;
                default:   base = '0;
            endcase
        end
        else
        begin
            base = acc_reg;
        end
        acc_next = mul_neg ? (base - pp_sh) : (base + pp_sh);
    end

    // Region classification
    logic signed [ACC_W-1:0] ax, bx, cx, dx, ex;
    logic signed [ACC_W-1:0] sum_bd, sum_ce, sum_be, sum_ad, span_den;
    logic                    in_tri;
    frac_mode_t              cls_mode;
    logic signed [ACC_W-1:0] cls_num, cls_den;

    always_comb
    begin
        ax = ACC_W'(a_reg);
        bx = ACC_W'(b_reg);
        cx = ACC_W'(c_reg);
        dx = ACC_W'(d_reg);
        ex = ACC_W'(e_reg);
        sum_bd = bx + dx;
        sum_ce = cx + ex;
        sum_be = bx + ex;
        sum_ad = ax + dx;
        span_den = ax - (bx <<< 1) + cx;
        in_tri = !(det_reg < (s_reg + t_reg));
        cls_mode = FM_ZERO;
        cls_num  = '0;
        cls_den  = '0;
        // every fraction has the form clamp(num / den) into [0, 1]
        priority if (det_reg == '0)
        begin
            cls_mode = FM_ZERO;
        end
        else if (in_tri)
        begin
            if (s_reg[ACC_W-1])
            begin
                if (t_reg[ACC_W-1] && d_reg[DOT_W-1])
                begin
                    cls_mode = FM_SF; cls_num = -dx; cls_den = ax;
                end
                else
                begin
                    cls_mode = FM_TF; cls_num = -ex; cls_den = cx;
                end
            end
            else if (t_reg[ACC_W-1])
            begin
                cls_mode = FM_SF; cls_num = -dx; cls_den = ax;
            end
            else
            begin
                cls_mode = FM_BOTH; cls_num = s_reg; cls_den = det_reg;
            end
        end
        else if (s_reg[ACC_W-1])
        begin
            if (sum_bd < sum_ce)
            begin
                cls_mode = FM_SF_COMP; cls_num = sum_ce - sum_bd; cls_den = span_den;
            end
            else
            begin
                cls_mode = FM_TF; cls_num = -ex; cls_den = cx;
            end
        end
        else if (t_reg[ACC_W-1])
        begin
            if (sum_be < sum_ad)
            begin
                cls_mode = FM_TF_COMP; cls_num = sum_ad - sum_be; cls_den = span_den;
            end
            else
            begin
                cls_mode = FM_SF; cls_num = -dx; cls_den = ax;
            end
        end
        else
        begin
            cls_mode = FM_SF_COMP; cls_num = sum_ce - sum_bd; cls_den = span_den;
        end
    end

    // Fraction and divider
    logic              num_pos, num_ge;
    logic [ACC_W-1:0]  rem2, rem_next;
    logic [31:0]       quo_next;

    assign num_pos = !num_reg[ACC_W-1] && (num_reg != '0);
    assign num_ge  = (num_reg >= den_reg);

    always_comb
    begin
        rem2 = rem_reg << 1;
        if (rem2 >= $unsigned(den_reg))
        begin
            rem_next = rem2 - $unsigned(den_reg);
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = rem2;
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    // Minimum and square root
    logic signed [ACC_W-1:0] best_sel;
    logic                    best_sat;
    logic [63:0]             sq_bit, sq_trial, sq_y_next, sq_res_next;

    assign best_sel = (!have_reg || (x_reg < best_reg)) ? x_reg : best_reg;
    assign best_sat = (best_sel[ACC_W-1:128] != '0);

    always_comb
    begin
        sq_bit   = 64'd1 << {ITER_LAST - iter_reg, 1'b0};
        sq_trial = sq_res_reg + sq_bit;
        if (sq_y_reg >= sq_trial)
        begin
            sq_y_next   = sq_y_reg - sq_trial;
            sq_res_next = (sq_res_reg >> 1) + sq_bit;
        end
        else
        begin
            sq_y_next   = sq_y_reg;
            sq_res_next = sq_res_reg >> 1;
        end
    end

    // Control and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fc_reg           <= '0;
            face_reg         <= '0;
            n_reg            <= '0;
            step_reg         <= '0;
            chunk_reg        <= '0;
            iter_reg         <= '0;
            second_reg       <= 1'b0;
            have_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            distance_reg     <= '0;
            empty_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fc_reg <= cfg_data;
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_fire && (cmd == CMD_QUERY))
                    begin
                        n_reg    <= n_calc;
                        face_reg <= '0;
                        have_reg <= 1'b0;
                        state_reg <= (n_calc == '0) ? S_DONE : S_FACE;
                    end
                end
                S_FACE: state_reg <= S_VA;
                S_VA:   state_reg <= S_VB;
                S_VB:   state_reg <= S_VC;
                S_VC:   state_reg <= S_VD;
                S_VD:
                begin
                    step_reg  <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    chunk_reg <= chunk_reg + 2'd1;
                    if (chunk_reg == CHUNK_LAST)
                    begin
                        if (step_reg == STEP_PRE_LAST)
                        begin
                            state_reg <= S_CLASS;
                        end
                        else if (step_reg == STEP_LAST)
                        begin
                            state_reg <= S_CMP;
                        end
                        else
                        begin
                            step_reg <= step_reg + STEP_W'(1);
                        end
                    end
                end
                S_CLASS:
                begin
                    second_reg <= 1'b0;
                    if (cls_mode == FM_ZERO)
                    begin
                        step_reg  <= STEP_POST_FIRST;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_FRAC;
                    end
                end
                S_FRAC:
                begin
                    iter_reg  <= '0;
                    state_reg <= (!num_pos || num_ge) ? S_FDONE : S_DIV;
                end
                S_DIV:
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_LAST)
                    begin
                        state_reg <= S_FDONE;
                    end
                end
                S_FDONE:
                begin
                    if ((mode_reg == FM_BOTH) && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_FRAC;
                    end
                    else
                    begin
                        step_reg  <= STEP_POST_FIRST;
                        state_reg <= S_MUL;
                    end
                end
                S_CMP:
                begin
                    have_reg <= 1'b1;
                    iter_reg <= '0;
                    if (last_face)
                    begin
                        state_reg <= best_sat ? S_DONE : S_SQRT;
                    end
                    else
                    begin
                        face_reg  <= face_reg + CNT_W'(1);
                        state_reg <= S_FACE;
                    end
                end
                S_SQRT:
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_LAST)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_result)
                    begin
                        distance_reg <= pend_dist_reg;
                        empty_reg    <= pend_empty_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        vout_reg <= vcorner_out;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && (cmd == CMD_QUERY))
                begin
                    px_reg <= coord_x;
                    py_reg <= coord_y;
                    pz_reg <= coord_z;
                    pend_empty_reg <= (n_calc == '0);
                    pend_dist_reg  <= '1;
                end
            end
            S_VA:
            begin
                corner_b_reg <= face_rdata[2*IDX_W-1:IDX_W];
                corner_c_reg <= face_rdata[IDX_W-1:0];
            end
            S_VB:
            begin
                v0x_reg <= vcx;
                v0y_reg <= vcy;
                v0z_reg <= vcz;
                q0_reg  <= DIFF_W'(px_reg) - DIFF_W'(vcx);
                q1_reg  <= DIFF_W'(py_reg) - DIFF_W'(vcy);
                q2_reg  <= DIFF_W'(pz_reg) - DIFF_W'(vcz);
            end
            S_VC:
            begin
                e00_reg <= DIFF_W'(vcx) - DIFF_W'(v0x_reg);
                e01_reg <= DIFF_W'(vcy) - DIFF_W'(v0y_reg);
                e02_reg <= DIFF_W'(vcz) - DIFF_W'(v0z_reg);
            end
            S_VD:
            begin
                e10_reg <= DIFF_W'(vcx) - DIFF_W'(v0x_reg);
                e11_reg <= DIFF_W'(vcy) - DIFF_W'(v0y_reg);
                e12_reg <= DIFF_W'(vcz) - DIFF_W'(v0z_reg);
            end
            S_MUL:
            begin
                acc_reg <= acc_next;
                if (chunk_reg == CHUNK_LAST)
                begin
                    unique case (op.dst)
                        DST_NONE: ;
                        DST_A:    a_reg   <= acc_next[DOT_W-1:0];
                        DST_B:    b_reg   <= acc_next[DOT_W-1:0];
                        DST_C:    c_reg   <= acc_next[DOT_W-1:0];
                        DST_D:    d_reg   <= acc_next[DOT_W-1:0];
                        DST_E:    e_reg   <= acc_next[DOT_W-1:0];
                        DST_DET:  det_reg <= acc_next;
                        DST_S:    s_reg   <= acc_next;
                        DST_T:    t_reg   <= acc_next;
                        DST_R:    r_reg   <= acc_next[OP_W-1:0];
                        DST_X:    x_reg   <= acc_next;
                        default:  ;
                    endcase
                end
            end
            S_CLASS:
            begin
                mode_reg <= cls_mode;
                num_reg  <= cls_num;
                den_reg  <= cls_den;
                if (cls_mode == FM_ZERO)
                begin
                    sf_reg <= '0;
                    tf_reg <= '0;
                end
            end
            S_FRAC:
            begin
                rem_reg <= $unsigned(num_reg);
                quo_reg <= '0;
                if (!num_pos)
                begin
                    f_reg <= '0;
                end
                else
                begin
                    f_reg <= FRAC_ONE;
                end
            end
            S_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                f_reg   <= {1'b0, quo_next};
            end
            S_FDONE:
            begin
                unique case (mode_reg)
                    FM_ZERO:
                    begin
                        sf_reg <= '0;
                        tf_reg <= '0;
                    end
                    FM_SF:
                    begin
                        sf_reg <= f_reg;
                        tf_reg <= '0;
                    end
                    FM_TF:
                    begin
                        sf_reg <= '0;
                        tf_reg <= f_reg;
                    end
                    FM_SF_COMP:
                    begin
                        sf_reg <= f_reg;
                        tf_reg <= FRAC_ONE - f_reg;
                    end
                    FM_TF_COMP:
                    begin
                        sf_reg <= FRAC_ONE - f_reg;
                        tf_reg <= f_reg;
                    end
                    FM_BOTH:
                    begin
                        // first pass gives s / det, second t / det
                        if (!second_reg)
                        begin
                            sf_reg  <= f_reg;
                            num_reg <= t_reg;
                            den_reg <= det_reg;
                        end
                        else
                        begin
                            tf_reg <= f_reg;
                        end
                    end
                    default: ;
                endcase
            end
            S_CMP:
            begin
                best_reg   <= best_sel;
                sq_y_reg   <= best_sel[127:64];
                sq_res_reg <= '0;
                if (best_sat)
                begin
                    pend_dist_reg <= '1;
                end
            end
            S_SQRT:
            begin
                sq_y_reg   <= sq_y_next;
                sq_res_reg <= sq_res_next;
                pend_dist_reg <= sq_res_next[COORD_W-1:0];
            end
            default: ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign distance     = distance_reg;
    assign empty_mesh   = empty_reg;

endmodule
